/* rtl/mbps_pkg.sv */
// Types and constants shared by the masked byte pattern search core.
`default_nettype none
package mbps_pkg;

	localparam int CFG_DATA_W   = 64;
	localparam int CFG_INDEX_W  = 3;
	localparam int CARE_W       = 16;
	localparam int LEN_CFG_W    = 5;
	localparam int MATCH_OFF_W  = 32;

	localparam int PATTERN_MAX_DEF  = 16;
	localparam int OFFSET_WIDTH_DEF = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_CARE_MASK    = 3'd2,
		REG_PATTERN_LEN  = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       region_end;
	} byte_word_t;

	typedef struct packed {
		logic                   found;
		logic [MATCH_OFF_W-1:0] match_offset;
	} result_word_t;

endpackage
`default_nettype wire

/* rtl/masked_byte_pattern_search_core.sv */
// Masked byte pattern search core: window, masked compare, result register.
//
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------
// byte     | byte_valid/byte_ready  | byte_word   (data_byte, region_end)
// result   | result_valid/ready     | result_word (found, match_offset)
// cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data (always ready)
//
// One byte per cycle while the result side keeps up. A byte is held in the input
// register, then the masked compare against the shifted window loads the result
// register. The input register only drains when the result register is empty
// or being taken, so a stalled result stalls the byte side after one more byte.
// Reset clears window, byte count and match flag and loads the register reset
// values.
`default_nettype none
module masked_byte_pattern_search_core #(
	parameter int PATTERN_MAX  = mbps_pkg::PATTERN_MAX_DEF,
	parameter int OFFSET_WIDTH = mbps_pkg::OFFSET_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                byte_valid,
	output logic                                byte_ready,
	input  mbps_pkg::byte_word_t                byte_word,
	output logic                                result_valid,
	input  logic                                result_ready,
	output mbps_pkg::result_word_t              result_word,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mbps_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int PAT_W = 8 * PATTERN_MAX;

	// configuration
	logic [CFG_DATA_W-1:0] pat_low_q;
	logic [CFG_DATA_W-1:0] pat_high_q;
	logic [CARE_W-1:0]     care_q;
	logic [LEN_CFG_W-1:0]  len_cfg_q;

	// input register
	logic       s1_valid;
	byte_word_t word_s1;

	// search state
	logic [7:0]              win_q [PATTERN_MAX];
	logic [OFFSET_WIDTH-1:0] pos_q;
	logic                    reported_q;

	logic [7:0]              win_next [PATTERN_MAX];
	logic [LEN_W-1:0]        len;
	logic [LEN_W-1:0]        shift_amt;
	logic [PAT_W-1:0]        pat_rev;
	logic [PAT_W-1:0]        pat_aligned;
	logic [PATTERN_MAX-1:0]  care_rev;
	logic [PATTERN_MAX-1:0]  care_aligned;
	logic                    enough;
	logic                    match;
	logic                    proc;
	logic                    has_res;
	logic [OFFSET_WIDTH-1:0] len_m1;
	logic [OFFSET_WIDTH-1:0] off_full;
	logic [MATCH_OFF_W-1:0]  off_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '1;
			len_cfg_q  <= LEN_CFG_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:  pat_low_q  <= cfg_data;
				REG_PATTERN_HIGH: pat_high_q <= cfg_data;
				REG_CARE_MASK:    care_q     <= cfg_data[CARE_W-1:0];
				REG_PATTERN_LEN:  len_cfg_q  <= cfg_data[LEN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// length in use, clamped to 1..PATTERN_MAX
	always_comb begin
		if (len_cfg_q == '0)
			len = LEN_W'(1);
		else if (len_cfg_q > LEN_CFG_W'(PATTERN_MAX))
			len = LEN_W'(PATTERN_MAX);
		else
			len = len_cfg_q[LEN_W-1:0];
	end

	// Reverse the pattern, then shift so that window tap j lines up with
	// pattern byte len-1-j. Care bits past the length shift in as zero.
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (i < 8)
				pat_rev[8*(PATTERN_MAX-1-i) +: 8] = pat_low_q[8*i +: 8];
			else
				pat_rev[8*(PATTERN_MAX-1-i) +: 8] = pat_high_q[8*(i-8) +: 8];
			care_rev[PATTERN_MAX-1-i] = care_q[i];
		end
	end

	assign shift_amt    = LEN_W'(PATTERN_MAX) - len;
	assign pat_aligned  = pat_rev >> {shift_amt, 3'b000};
	assign care_aligned = care_rev >> shift_amt;

	always_comb begin
		win_next[0] = word_s1.data_byte;
		for (int j = 1; j < PATTERN_MAX; j++)
			win_next[j] = win_q[j-1];
	end

	assign len_m1 = OFFSET_WIDTH'(len - LEN_W'(1));
	assign enough = pos_q >= len_m1;

	always_comb begin
		match = enough;
		for (int j = 0; j < PATTERN_MAX; j++) begin
			if (care_aligned[j] && (pat_aligned[8*j +: 8] != win_next[j]))
				match = 1'b0;
		end
	end

	assign off_full = pos_q - len_m1;
	generate
		if (OFFSET_WIDTH >= MATCH_OFF_W) begin : g_off_cut
			assign off_out = off_full[MATCH_OFF_W-1:0];
		end else begin : g_off_ext
			assign off_out = MATCH_OFF_W'(off_full);
		end
	endgenerate

	assign proc       = s1_valid && (!result_valid || result_ready);
	assign byte_ready = !s1_valid || proc;
	assign has_res    = !reported_q && (match || word_s1.region_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (byte_ready) begin
			s1_valid <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid)
			word_s1 <= byte_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < PATTERN_MAX; j++)
				win_q[j] <= '0;
			pos_q      <= '0;
			reported_q <= 1'b0;
		end else if (proc) begin
			if (word_s1.region_end) begin
				for (int j = 0; j < PATTERN_MAX; j++)
					win_q[j] <= '0;
				pos_q      <= '0;
				reported_q <= 1'b0;
			end else begin
				win_q <= win_next;
				if (pos_q != '1)
					pos_q <= pos_q + OFFSET_WIDTH'(1);
				if (match)
					reported_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (proc && has_res) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && has_res) begin
			result_word.found        <= match;
			result_word.match_offset <= match ? off_out : '0;
		end
	end

	// a result decided in this cycle is shown in the next
	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && has_res) |=> result_valid)
		else $error("result lost");

	// end of region always returns the search state to zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && word_s1.region_end) |=> (pos_q == '0) && !reported_q)
		else $error("search state not cleared at region end");

	// the match flag only sets alongside a found result
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(reported_q) |-> $past(proc && has_res && match))
		else $error("match flag set without a result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_word.found) |-> (result_word.match_offset == '0))
		else $error("not-found result with nonzero offset");

endmodule
`default_nettype wire

/* tb/masked_byte_pattern_search_core_test.sv */
// Self-checking testbench for the masked byte pattern search core.
`timescale 1ns / 1ps
module masked_byte_pattern_search_core_test;
	import mbps_pkg::*;

	localparam int DRAIN_CYCLES   = 6;
	localparam int HOLD_CYCLES    = 80;
	localparam int PHASE_BYTES    = 48;
	localparam int RANDOM_PHASES  = 10;
	localparam int MAX_REGION     = 160;
	localparam int UNMAPPED_FIRST = REG_PATTERN_LEN + 1;
	localparam int UNMAPPED_LAST  = (1 << CFG_INDEX_W) - 1;

	// Mirrors the search state and predicts the result words that the byte words give.
	class match_tracker;
		logic [63:0]  pat_low;
		logic [63:0]  pat_high;
		logic [15:0]  care;
		logic [4:0]   pat_len;
		logic [7:0]   win [16];
		logic [31:0]  count;
		bit           reported;
		result_word_t expected_hits [$];
		int           errors;

		function new();
			pat_low  = '0;
			pat_high = '0;
			care     = 16'hFFFF;
			pat_len  = 5'd1;
			errors   = 0;
			clear_region();
		endfunction

		function void clear_region();
			foreach (win[i]) win[i] = 8'h00;
			count    = '0;
			reported = 1'b0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] d);
			case (idx)
				REG_PATTERN_LOW: begin
					pat_low = d;
				end
				REG_PATTERN_HIGH: begin
					pat_high = d;
				end
				REG_CARE_MASK: begin
					care = d[15:0];
				end
				REG_PATTERN_LEN: begin
					pat_len = d[4:0];
				end
				default: begin
				end
			endcase
		endfunction

		// length in use: 0 acts as 1, anything past the max is clamped
		function int unsigned span();
			if (pat_len == 0)
				return 1;
			if (pat_len > PATTERN_MAX_DEF)
				return PATTERN_MAX_DEF;
			return pat_len;
		endfunction

		function int pending();
			return expected_hits.size();
		endfunction

		function void take_byte(byte_word_t w);
			int unsigned  n;
			int           i;
			bit           hit;
			logic [127:0] pat;
			result_word_t r;
			n   = span();
			pat = {pat_high, pat_low};
			for (i = 15; i > 0; i--)
				win[i] = win[i-1];
			win[0] = w.data_byte;
			// pattern byte 0 lines up with the oldest byte of the compared stretch
			hit = ({1'b0, count} + 33'd1) >= n;
			for (i = 0; i < n; i++)
				if (care[i] && pat[8*i +: 8] != win[n-1-i])
					hit = 1'b0;
			if (!reported) begin
				if (hit) begin
					r.found        = 1'b1;
					r.match_offset = count - (n - 1);
					reported       = 1'b1;
					expected_hits.push_back(r);
				end else if (w.region_end) begin
					r.found        = 1'b0;
					r.match_offset = '0;
					expected_hits.push_back(r);
				end
			end
			if (count != '1)
				count++;
			if (w.region_end)
				clear_region();
		endfunction

		function void check_result(result_word_t r);
			result_word_t x;
			if (expected_hits.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word: expected none, got found=%0b offset=%0d",
					$time, r.found, r.match_offset);
				return;
			end
			x = expected_hits.pop_front();
			if (r.found !== x.found) begin
				errors++;
				$display("%0t: found mismatch: expected %0b, got %0b", $time, x.found, r.found);
			end
			if (r.match_offset !== x.match_offset) begin
				errors++;
				$display("%0t: match_offset mismatch: expected %0d, got %0d",
					$time, x.match_offset, r.match_offset);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   byte_valid;
	logic                   byte_ready;
	byte_word_t             byte_word;
	logic                   result_valid;
	logic                   result_ready;
	result_word_t           result_word;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	match_tracker tracker = new();
	bit           tx_idle_on;
	bit           rx_idle_on;
	bit           hold_results;

	masked_byte_pattern_search_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_word    (byte_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic send_byte(input logic [7:0] d, input bit last);
		int unsigned gap;
		byte_word_t  w;
		gap          = tx_idle_on ? $urandom_range(0, 9) : 0;
		w.data_byte  = d;
		w.region_end = last;
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_word  <= w;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		tracker.take_byte(w);
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.write_reg(idx, d);
	endtask

	task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
			input logic [15:0] care, input logic [4:0] len);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		// upper bits of the narrow registers carry noise
		write_reg(REG_CARE_MASK, {junk[63:16], care});
		write_reg(REG_PATTERN_LEN, {junk[63:5], len});
		write_reg(CFG_INDEX_W'($urandom_range(UNMAPPED_FIRST, UNMAPPED_LAST)),
			{$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	// sender stops until every expected word is back, then lets the pipe empty
	task automatic wait_idle();
		byte_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int unsigned budget);
		logic [7:0]   region_bytes [MAX_REGION];
		logic [127:0] pat;
		int unsigned  sent;
		int unsigned  n;
		int unsigned  eff;
		int unsigned  at;
		int unsigned  k;
		int           i;
		sent = 0;
		pat  = {tracker.pat_high, tracker.pat_low};
		eff  = tracker.span();
		while (sent < budget) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, MAX_REGION)
				: $urandom_range(1, 24);
			for (i = 0; i < n; i++)
				region_bytes[i] = 8'($urandom_range(0, 255));
			// mostly plant the pattern, wildcards keep random bytes
			if ($urandom_range(0, 3) != 0 && n >= eff) begin
				at = ($urandom_range(0, 3) == 0) ? n - eff : $urandom_range(0, n - eff);
				for (i = 0; i < eff; i++)
					if (tracker.care[i])
						region_bytes[at + i] = pat[8*i +: 8];
				if ($urandom_range(0, 4) == 0) begin
					k = $urandom_range(0, eff - 1);
					region_bytes[at + k][$urandom_range(0, 7)] ^= 1'b1;
				end
			end
			for (i = 0; i < n; i++)
				send_byte(region_bytes[i], i == n - 1);
			sent += n;
		end
	endtask

	initial begin : result_sink
		int unsigned gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				gap          = HOLD_CYCLES;
				hold_results = 1'b0;
			end else begin
				gap = rx_idle_on ? $urandom_range(0, 9) : 0;
			end
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			tracker.check_result(result_word);
		end
	end

	initial begin : stimulus
		logic [127:0] pat;
		logic [63:0]  lo;
		logic [63:0]  hi;
		logic [15:0]  care;
		logic [4:0]   len;
		int           i;
		int           p;
		arst_n       <= 1'b0;
		byte_valid   <= 1'b0;
		byte_word    <= '0;
		result_ready <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_PATTERN_LOW;
		cfg_data     <= '0;
		tx_idle_on   = 1'b1;
		rx_idle_on   = 1'b1;
		hold_results = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: single byte 0x00, every bit cared for
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_idle();

		// full-length pattern matched on the closing byte, then a too-short region
		lo = 64'hFF00_5AA5_0FF0_8001;
		hi = 64'h7F80_C33C_1EE1_00FF;
		configure(lo, hi, 16'hFFFF, 5'd16);
		pat = {hi, lo};
		for (i = 0; i < 16; i++)
			send_byte(pat[8*i +: 8], i == 15);
		for (i = 0; i < 3; i++)
			send_byte(pat[8*i +: 8], i == 2);
		wait_idle();

		// every byte its own region and all wildcards: the result side backs up
		configure({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd1);
		tx_idle_on   = 1'b0;
		hold_results = 1'b1;
		for (i = 0; i < 40; i++)
			send_byte(8'($urandom_range(0, 255)), 1'b1);
		wait_idle();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				1: begin
					lo = '1;
					hi = '1;
				end
				2: begin
					lo = '0;
					hi = '0;
				end
				default: begin
					lo = {$urandom, $urandom};
					hi = {$urandom, $urandom};
				end
			endcase
			case (p % 4)
				0: care = 16'hFFFF;
				1: care = 16'h0000;
				default: care = 16'($urandom_range(0, 16'hFFFF));
			endcase
			case (p)
				0: len = 5'd16;
				1: len = 5'd1;
				2: len = 5'd0;
				3: len = 5'd31;
				4: len = 5'd17;
				default: len = 5'($urandom_range(2, 15));
			endcase
			configure(lo, hi, care, len);
			tx_idle_on = (p % 3) != 1 && p != 7;
			rx_idle_on = (p % 3) != 2 && p != 7;
			run_phase(PHASE_BYTES);
			wait_idle();
		end

		byte_valid <= 1'b0;
		for (i = 0; i < 5000 && tracker.pending() != 0; i++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
